// ----- rtl/core/fixed_point_alu_assert.svh -----
// assertion macros for the fixed point alu checker
// expects clk and arst_n in the scope of each use
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FPALU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FPALU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/fpalu_pkg.sv -----
// shared types, mode codes and saturation helper for the fixed point alu
// no dependencies
`default_nettype none

package fpalu_pkg;
	localparam int DATA_W = 32;
	localparam int DIV_STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES = DATA_W / DIV_STEPS_PER_STAGE;
	localparam int PIPE_LATENCY = DIV_STAGES + 4;

	localparam logic [3:0] MODE_ADD = 4'd0;
	localparam logic [3:0] MODE_SUB = 4'd1;
	localparam logic [3:0] MODE_MUL = 4'd2;
	localparam logic [3:0] MODE_DIV = 4'd3;
	localparam logic [3:0] MODE_MIN = 4'd4;
	localparam logic [3:0] MODE_MAX = 4'd5;
	localparam logic [3:0] MODE_INC = 4'd6;
	localparam logic [3:0] MODE_DEC = 4'd7;
	localparam logic [3:0] MODE_TO_INT = 4'd8;
	localparam logic [3:0] MODE_FROM_INT = 4'd9;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic [DATA_W-1:0] word_t;

	typedef struct packed {
		word_t mag_a;
		word_t mag_b;
		logic  neg;
	} opnd_t;

	typedef struct packed {
		logic [3:0] mode;
		word_t      simple_result;
		logic       simple_ovf;
		logic       a_greater;
		logic       a_less;
		logic       a_equal;
		logic       b_zero;
	} side_t;

	typedef struct packed {
		word_t value;
		logic  ovf;
	} sat_t;

	function automatic sat_t saturate(input logic [DATA_W:0] mag, input logic neg,
			input logic big);
		sat_t r;
		logic over;
		over = big || (neg ? (mag > {1'b0, SAT_MIN}) : (mag > {1'b0, SAT_MAX}));
		r.ovf = over;
		if (over) begin
			r.value = neg ? SAT_MIN : SAT_MAX;
		end else if (neg) begin
			r.value = ~mag[DATA_W-1:0] + word_t'(1);
		end else begin
			r.value = mag[DATA_W-1:0];
		end
		return r;
	endfunction
endpackage

`default_nettype wire

// ----- rtl/core/fpalu_front.sv -----
// first stage: add/sub/inc/dec, min/max, shifts, compare, operand magnitudes
// depends on fpalu_pkg
`default_nettype none

module fpalu_front import fpalu_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                     clk,
	input  logic [3:0]               mode,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output side_t                    side_s1,
	output opnd_t                    opnd_s1
);
	logic [DATA_W:0] add_x;
	logic [DATA_W:0] add_y;
	logic [DATA_W:0] add_sum;
	logic            add_cin;
	logic            add_ovf;
	word_t           add_val;
	logic [FRACTION_BITS:0] fi_top;
	logic            fi_ovf;
	word_t           fi_val;
	word_t           ti_val;
	logic            gt;
	logic            lt;
	logic            eq;
	word_t           simple_val;
	logic            simple_ovf;
	side_t           side_d;
	opnd_t           opnd_d;

	always_comb begin
		add_x = {operand_a[DATA_W-1], operand_a};
		add_cin = 1'b0;
		case (mode)
			MODE_SUB: begin
				add_y = ~{operand_b[DATA_W-1], operand_b};
				add_cin = 1'b1;
			end
			MODE_INC: add_y = {{DATA_W{1'b0}}, 1'b1};
			MODE_DEC: add_y = {(DATA_W+1){1'b1}};
			default:  add_y = {operand_b[DATA_W-1], operand_b};
		endcase
		add_sum = add_x + add_y + {{DATA_W{1'b0}}, add_cin};
		add_ovf = add_sum[DATA_W] ^ add_sum[DATA_W-1];
		add_val = add_ovf ? (add_sum[DATA_W] ? SAT_MIN : SAT_MAX) : add_sum[DATA_W-1:0];
	end

	always_comb begin
		fi_top = operand_a[DATA_W-1 -: FRACTION_BITS+1];
		fi_ovf = !((&fi_top) || !(|fi_top));
		fi_val = fi_ovf ? (operand_a[DATA_W-1] ? SAT_MIN : SAT_MAX)
			: (word_t'(operand_a) << FRACTION_BITS);
		ti_val = word_t'(operand_a >>> FRACTION_BITS);
		gt = operand_a > operand_b;
		lt = operand_a < operand_b;
		eq = operand_a == operand_b;
	end

	always_comb begin
		simple_ovf = 1'b0;
		case (mode) inside
			MODE_ADD, MODE_SUB, MODE_INC, MODE_DEC: begin
				simple_val = add_val;
				simple_ovf = add_ovf;
			end
			MODE_MIN:      simple_val = gt ? word_t'(operand_b) : word_t'(operand_a);
			MODE_MAX:      simple_val = lt ? word_t'(operand_b) : word_t'(operand_a);
			MODE_TO_INT:   simple_val = ti_val;
			MODE_FROM_INT: begin
				simple_val = fi_val;
				simple_ovf = fi_ovf;
			end
			default:       simple_val = '0;
		endcase
	end

	always_comb begin
		side_d.mode = mode;
		side_d.simple_result = simple_val;
		side_d.simple_ovf = simple_ovf;
		side_d.a_greater = gt;
		side_d.a_less = lt;
		side_d.a_equal = eq;
		side_d.b_zero = operand_b == '0;
		opnd_d.mag_a = operand_a[DATA_W-1] ? (~word_t'(operand_a) + word_t'(1))
			: word_t'(operand_a);
		opnd_d.mag_b = operand_b[DATA_W-1] ? (~word_t'(operand_b) + word_t'(1))
			: word_t'(operand_b);
		opnd_d.neg = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_d;
		opnd_s1 <= opnd_d;
	end
endmodule

`default_nettype wire

// ----- rtl/core/fpalu_mul.sv -----
// two-stage multiplier: magnitude product, then round and saturate
// depends on fpalu_pkg
`default_nettype none

module fpalu_mul import fpalu_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic  clk,
	input  opnd_t opnd_s1,
	output sat_t  mul_s3
);
	localparam logic [2*DATA_W-1:0] HALF = {{(2*DATA_W-1){1'b0}}, 1'b1} << (FRACTION_BITS-1);

	logic [2*DATA_W-1:0] prod_s2;
	logic                neg_s2;
	logic [2*DATA_W-1:0] rnd;
	logic [2*DATA_W-1:0] shifted;

	always_ff @(posedge clk) begin
		prod_s2 <= (2*DATA_W)'(opnd_s1.mag_a) * (2*DATA_W)'(opnd_s1.mag_b);
		neg_s2 <= opnd_s1.neg;
	end

	always_comb begin
		rnd = prod_s2 + HALF;
		shifted = rnd >> FRACTION_BITS;
	end

	always_ff @(posedge clk) begin
		mul_s3 <= saturate(shifted[DATA_W:0], neg_s2, |shifted[2*DATA_W-1:DATA_W+1]);
	end
endmodule

`default_nettype wire

// ----- rtl/core/fpalu_div.sv -----
// pipelined restoring divider, several quotient bits per stage, round and saturate
// depends on fpalu_pkg
`default_nettype none

module fpalu_div import fpalu_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic  clk,
	input  opnd_t opnd_s1,
	output sat_t  div_s11
);
	typedef struct packed {
		word_t rem;
		word_t quo;
		word_t den;
		logic  neg;
		logic  big;
	} div_stage_t;

	div_stage_t stg_s [DIV_STAGES+1];
	div_stage_t setup;
	word_t      n_hi;
	logic            up;
	logic [DATA_W:0] q_round;

	// dividend is mag_a shifted up by the fraction bits
	always_comb begin
		n_hi = opnd_s1.mag_a >> (DATA_W - FRACTION_BITS);
		setup.rem = n_hi;
		setup.quo = opnd_s1.mag_a << FRACTION_BITS;
		setup.den = opnd_s1.mag_b;
		setup.neg = opnd_s1.neg;
		setup.big = n_hi >= opnd_s1.mag_b;
	end

	always_ff @(posedge clk) begin
		stg_s[0] <= setup;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
		div_stage_t      nxt;
		logic [DATA_W:0] trial;
		logic            take;

		always_comb begin
			nxt = stg_s[k];
			trial = '0;
			take = 1'b0;
			for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
				trial = {nxt.rem, nxt.quo[DATA_W-1]};
				take = trial >= {1'b0, nxt.den};
				nxt.quo = {nxt.quo[DATA_W-2:0], take};
				nxt.rem = take ? word_t'(trial - {1'b0, nxt.den}) : trial[DATA_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			stg_s[k+1] <= nxt;
		end
	end

	// round half away from zero on the magnitude
	always_comb begin
		up = {stg_s[DIV_STAGES].rem, 1'b0} >= {1'b0, stg_s[DIV_STAGES].den};
		q_round = {1'b0, stg_s[DIV_STAGES].quo} + {{DATA_W{1'b0}}, up};
	end

	always_ff @(posedge clk) begin
		div_s11 <= saturate(q_round, stg_s[DIV_STAGES].neg, stg_s[DIV_STAGES].big);
	end
endmodule

`default_nettype wire

// ----- rtl/core/fixed_point_alu.sv -----
// fixed point alu top level: front stage, multiplier, divider, result select
// depends on fpalu_pkg, fpalu_front, fpalu_mul, fpalu_div
//
// signed Q(32-F).F alu, one operation per request, no stored state
// request: drive mode, operand_a, operand_b and pulse start; a request is
//   taken on every clock edge where start is high and busy is low
// busy stays low: the pipeline takes a request in every cycle
// result: done is high for one cycle with result and flags; the receiver
//   cannot hold it off, so the pipeline never stalls
// every mode has the same latency from the accepting edge to the edge that
//   takes the result
// throughput: one request per cycle
// depth is set by the divider, which retires 4 quotient bits per stage
//   over 8 stages; products go through one 32x32 multiply stage
// reset clears the valid bits only; requests in flight are dropped
`default_nettype none

module fixed_point_alu import fpalu_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [3:0]               mode,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output logic                     done,
	output logic signed [DATA_W-1:0] result,
	output logic                     a_greater,
	output logic                     a_less,
	output logic                     a_equal,
	output logic                     overflowed,
	output logic                     divided_by_zero
);
	localparam int ALIGN = DIV_STAGES + 2;

	logic [PIPE_LATENCY-1:0] valid_s;
	side_t side_s1;
	opnd_t opnd_s1;
	sat_t  mul_s3;
	sat_t  div_s11;
	side_t side_dly_s [ALIGN];
	sat_t  mul_dly_s [DIV_STAGES];
	side_t fin;
	sat_t  pick;
	logic  dz;

	fpalu_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk       (clk),
		.mode      (mode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.side_s1   (side_s1),
		.opnd_s1   (opnd_s1)
	);

	fpalu_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
		.clk     (clk),
		.opnd_s1 (opnd_s1),
		.mul_s3  (mul_s3)
	);

	fpalu_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk     (clk),
		.opnd_s1 (opnd_s1),
		.div_s11 (div_s11)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[PIPE_LATENCY-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		side_dly_s[0] <= side_s1;
		for (int i = 1; i < ALIGN; i++) begin
			side_dly_s[i] <= side_dly_s[i-1];
		end
		mul_dly_s[0] <= mul_s3;
		for (int i = 1; i < DIV_STAGES; i++) begin
			mul_dly_s[i] <= mul_dly_s[i-1];
		end
	end

	always_comb begin
		fin = side_dly_s[ALIGN-1];
		dz = 1'b0;
		unique case (fin.mode)
			MODE_MUL: pick = mul_dly_s[DIV_STAGES-1];
			MODE_DIV: begin
				if (fin.b_zero) begin
					pick.value = '0;
					pick.ovf = 1'b0;
					dz = 1'b1;
				end else begin
					pick = div_s11;
				end
			end
			default: begin
				pick.value = fin.simple_result;
				pick.ovf = fin.simple_ovf;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		result <= pick.value;
		overflowed <= pick.ovf;
		divided_by_zero <= dz;
		a_greater <= fin.a_greater;
		a_less <= fin.a_less;
		a_equal <= fin.a_equal;
	end

	assign done = valid_s[PIPE_LATENCY-1];
	assign busy = 1'b0;
endmodule

`default_nettype wire

// ----- rtl/core/fpalu_checker.sv -----
// port-level checks for the fixed point alu, bound to the top level
// depends on fpalu_pkg and fixed_point_alu_assert.svh
`default_nettype none

`include "fixed_point_alu_assert.svh"

module fpalu_checker import fpalu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [DATA_W-1:0] result,
	input logic              a_greater,
	input logic              a_less,
	input logic              a_equal,
	input logic              overflowed,
	input logic              divided_by_zero
);
	`FPALU_ASSERT_NEXT(busy_stays_low, 1'b1, !busy, "busy raised")
	`FPALU_ASSERT_IMPL(done_after_request, done, $past(start, PIPE_LATENCY), "done without request")
	`FPALU_ASSERT_IMPL(one_compare_flag, done, (a_greater ^ a_less ^ a_equal) && !(a_greater && a_less && a_equal), "compare flags not exclusive")
	`FPALU_ASSERT_IMPL(div_zero_clean, done && divided_by_zero, (result == '0) && !overflowed, "divide by zero result not cleared")
endmodule

bind fixed_point_alu fpalu_checker u_fpalu_checker (.*);

`default_nettype wire
